FILE: rtl/pkrt_pkg.sv
// ----------------------------------------------------------------------------
// pkrt_pkg
// Shared types, constants and helpers of the partition key refcount table.
// ----------------------------------------------------------------------------
package pkrt_pkg;

  localparam int KEY_W   = 16;
  localparam int CNT_W   = 3;
  localparam int LOW_W   = 15;
  localparam int SLOT_W  = 2;

  localparam int CONTEXT_ENTRIES_DEF = 4;
  localparam int SHARED_ENTRIES_DEF  = 4;

  localparam logic [LOW_W-1:0] LOW_ONES  = 15'h7FFF;
  localparam logic [CNT_W-1:0] COUNT_MAX = 3'd7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Address width of a store, at least one bit.
  function automatic int idx_width(input int depth);
    return (depth > 1) ? $clog2(depth) : 1;
  endfunction

endpackage

FILE: rtl/pkrt_ram.sv
// ----------------------------------------------------------------------------
// pkrt_ram
// One write port, one read port synchronous RAM, registered read data.
// Per-entry valid bits cleared at reset; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module pkrt_ram
  import pkrt_pkg::*;
#(
  parameter int DEPTH = 4,
  parameter int WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       we,
  input  logic [idx_width(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]           wdata,
  input  logic [idx_width(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [WIDTH-1:0] rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

FILE: rtl/partition_key_refcount_table.sv
// ----------------------------------------------------------------------------
// partition_key_refcount_table
// Context partition key table backed by a shared, reference counted key table.
// ----------------------------------------------------------------------------
// One input transaction writes context entry in_slot with in_new_key. The old
// key gives up its reference in the shared table (slot freed at zero), then
// the new key is matched, flagged as a membership conflict, placed in the
// first empty shared slot, or rejected as table full; a rejected key is
// stored as zero; a new key with zero or all-ones low bits skips the
// shared table. Both tables live in RAMs with one read port and registered
// read data; the sequencer walks the shared table entry by entry (address,
// then check and write back). An item makes at most one removal and one add
// walk, none when the key is unchanged; an out-of-range slot makes neither
// and reports key zero. Every store reads as zero after reset, with no
// clearing pass. in_stall is high while an item is in work; a finished
// result waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module partition_key_refcount_table
  import pkrt_pkg::*;
#(
  parameter int CONTEXT_ENTRIES = CONTEXT_ENTRIES_DEF,
  parameter int SHARED_ENTRIES  = SHARED_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [KEY_W-1:0]  in_new_key,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [KEY_W-1:0]  out_stored_key,
  output logic              out_table_changed,
  output logic [1:0]        out_status
);

  localparam int CIDX_W = idx_width(CONTEXT_ENTRIES);
  localparam int SIDX_W = idx_width(SHARED_ENTRIES);
  localparam int SH_W   = KEY_W + CNT_W;
  localparam logic [6:0]        CTX_LIMIT = 7'(CONTEXT_ENTRIES);
  localparam logic [SIDX_W-1:0] SH_LAST   = SIDX_W'(SHARED_ENTRIES - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CTX_WAIT,
    S_CTX_EVAL,
    S_RM_RD,
    S_RM_CHK,
    S_ADD_START,
    S_AD_RD,
    S_AD_CHK,
    S_CTX_WR,
    S_FIN
  } state_t;

  state_t            state_r;
  logic [CIDX_W-1:0] idx_r;
  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  old_r;
  logic [KEY_W-1:0]  store_r;
  logic              changed_r;
  status_t           status_r;
  logic [SIDX_W-1:0] ptr_r;
  logic              any_empty_r;
  logic [SIDX_W-1:0] first_r;

  logic              out_valid_r;
  logic [KEY_W-1:0]  out_key_r;
  logic              out_changed_r;
  status_t           out_status_r;

  // context store
  logic              ctx_we;
  logic [KEY_W-1:0]  ctx_rdata;

  // shared store: {key, count}
  logic              sh_we;
  logic [SIDX_W-1:0] sh_waddr;
  logic [SH_W-1:0]   sh_wdata;
  logic [SH_W-1:0]   sh_rdata;
  logic [KEY_W-1:0]  sh_key;
  logic [CNT_W-1:0]  sh_cnt;

  // scan decode
  logic              sh_last;
  logic              rm_hit;
  logic              ad_empty;
  logic              ad_match;
  logic              ad_conf;
  logic              have_empty;
  logic [SIDX_W-1:0] fe_idx;
  logic              slot_ok;

  pkrt_ram #(
    .DEPTH (CONTEXT_ENTRIES),
    .WIDTH (KEY_W)
  ) u_ctx_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ctx_we),
    .waddr (idx_r),
    .wdata (store_r),
    .raddr (idx_r),
    .rdata (ctx_rdata)
  );

  pkrt_ram #(
    .DEPTH (SHARED_ENTRIES),
    .WIDTH (SH_W)
  ) u_sh_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (sh_we),
    .waddr (sh_waddr),
    .wdata (sh_wdata),
    .raddr (ptr_r),
    .rdata (sh_rdata)
  );

  assign sh_key  = sh_rdata[SH_W-1:CNT_W];
  assign sh_cnt  = sh_rdata[CNT_W-1:0];
  assign sh_last = (ptr_r == SH_LAST);
  assign slot_ok = ({5'b0, in_slot} < CTX_LIMIT);

  assign rm_hit     = (sh_key == old_r);
  assign ad_empty   = (sh_key == '0);
  assign ad_match   = !ad_empty && (sh_key == key_r);
  assign ad_conf    = !ad_empty && !ad_match && (sh_key[LOW_W-1:0] == key_r[LOW_W-1:0]);
  assign have_empty = any_empty_r || ad_empty;
  assign fe_idx     = any_empty_r ? first_r : ptr_r;

  assign ctx_we = (state_r == S_CTX_WR);

  // shared table write back
  always_comb begin
    sh_we    = 1'b0;
    sh_waddr = ptr_r;
    sh_wdata = '0;
    case (state_r)
      S_RM_CHK: begin
        if (rm_hit) begin
          sh_we = 1'b1;
          if (sh_cnt > CNT_W'(1)) begin
            sh_wdata = {sh_key, sh_cnt - CNT_W'(1)};
          end
        end
      end
      S_AD_CHK: begin
        if (ad_match) begin
          sh_we    = (sh_cnt < COUNT_MAX);
          sh_wdata = {sh_key, sh_cnt + CNT_W'(1)};
        end else if (!ad_conf && sh_last && have_empty) begin
          // new key takes the first empty slot
          sh_we    = 1'b1;
          sh_waddr = fe_idx;
          sh_wdata = {key_r, CNT_W'(1)};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            idx_r     <= CIDX_W'(in_slot);
            key_r     <= in_new_key;
            changed_r <= 1'b0;
            status_r  <= ST_OK;
            if (slot_ok) begin
              state_r <= S_CTX_WAIT;
            end else begin
              store_r <= '0;
              state_r <= S_FIN;
            end
          end
        end
        S_CTX_WAIT: begin
          state_r <= S_CTX_EVAL;
        end
        S_CTX_EVAL: begin
          old_r   <= ctx_rdata;
          store_r <= key_r;
          ptr_r   <= '0;
          if (ctx_rdata == key_r) begin
            state_r <= S_CTX_WR;
          end else if (ctx_rdata[LOW_W-1:0] != '0) begin
            state_r <= S_RM_RD;
          end else begin
            state_r <= S_ADD_START;
          end
        end
        S_RM_RD: begin
          state_r <= S_RM_CHK;
        end
        S_RM_CHK: begin
          if (rm_hit) begin
            if (sh_cnt <= CNT_W'(1)) begin
              changed_r <= 1'b1;
            end
            state_r <= S_ADD_START;
          end else if (sh_last) begin
            state_r <= S_ADD_START;
          end else begin
            ptr_r   <= ptr_r + SIDX_W'(1);
            state_r <= S_RM_RD;
          end
        end
        S_ADD_START: begin
          ptr_r       <= '0;
          any_empty_r <= 1'b0;
          // zero and all-ones low bits bypass the shared table
          if (key_r[LOW_W-1:0] == '0 || key_r[LOW_W-1:0] == LOW_ONES) begin
            state_r <= S_CTX_WR;
          end else begin
            state_r <= S_AD_RD;
          end
        end
        S_AD_RD: begin
          state_r <= S_AD_CHK;
        end
        S_AD_CHK: begin
          if (ad_empty && !any_empty_r) begin
            any_empty_r <= 1'b1;
            first_r     <= ptr_r;
          end
          if (ad_match) begin
            state_r <= S_CTX_WR;
          end else if (ad_conf) begin
            status_r <= ST_CONFLICT;
            store_r  <= '0;
            state_r  <= S_CTX_WR;
          end else if (sh_last) begin
            if (have_empty) begin
              changed_r <= 1'b1;
            end else begin
              status_r <= ST_FULL;
              store_r  <= '0;
            end
            state_r <= S_CTX_WR;
          end else begin
            ptr_r   <= ptr_r + SIDX_W'(1);
            state_r <= S_AD_RD;
          end
        end
        S_CTX_WR: begin
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r   <= 1'b1;
            out_key_r     <= store_r;
            out_changed_r <= changed_r;
            out_status_r  <= status_r;
            state_r       <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall          = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_stored_key    = out_key_r;
  assign out_table_changed = out_changed_r;
  assign out_status        = out_status_r;

endmodule

FILE: sim/partition_key_refcount_table_check.sv
// ----------------------------------------------------------------------------
// partition_key_refcount_table_check
// Channel monitor, result predictor and scoreboard for the key table.
// ----------------------------------------------------------------------------
// Every accepted input transaction is run through a behavioral copy of the
// context and shared key tables. The predicted result is queued, and each
// accepted result transaction is compared field by field with the oldest
// prediction. The failure count and the number of outstanding predictions
// go back to the test top.
// ----------------------------------------------------------------------------
module partition_key_refcount_table_check
  import pkrt_pkg::*;
#(
  parameter int CONTEXT_ENTRIES = CONTEXT_ENTRIES_DEF,
  parameter int SHARED_ENTRIES  = SHARED_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [SLOT_W-1:0] in_slot,
  input  logic [KEY_W-1:0]  in_new_key,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [KEY_W-1:0]  out_stored_key,
  input  logic              out_table_changed,
  input  logic [1:0]        out_status,
  output int                errors,
  output int                pending
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             changed;
    status_t          status;
  } key_result_t;

  key_result_t      key_results_q[$];
  logic [KEY_W-1:0] ctx_keys [CONTEXT_ENTRIES];
  logic [KEY_W-1:0] shr_keys [SHARED_ENTRIES];
  logic [CNT_W-1:0] shr_refs [SHARED_ENTRIES];

  // Drop one reference of key; 1 when its shared slot was freed.
  function automatic bit release_key(input logic [KEY_W-1:0] key);
    for (int i = 0; i < SHARED_ENTRIES; i++) begin
      if (shr_keys[i] == key) begin
        if (shr_refs[i] <= 1) begin
          shr_refs[i] = '0;
          shr_keys[i] = '0;
          return 1'b1;
        end
        shr_refs[i] = shr_refs[i] - 1'b1;
        return 1'b0;
      end
    end
    return 1'b0;
  endfunction

  // Add a reference of key: match, conflict, new slot or table full.
  function automatic status_t claim_key(input logic [KEY_W-1:0] key, output bit filled);
    bit any_empty;
    filled    = 1'b0;
    any_empty = 1'b0;
    if (key[LOW_W-1:0] == LOW_ONES) return ST_OK;
    for (int i = 0; i < SHARED_ENTRIES; i++) begin
      if (shr_keys[i] == '0) begin
        any_empty = 1'b1;
        continue;
      end
      if (shr_keys[i] == key) begin
        if (shr_refs[i] < COUNT_MAX) shr_refs[i] = shr_refs[i] + 1'b1;
        return ST_OK;
      end
      if (shr_keys[i][LOW_W-1:0] == key[LOW_W-1:0]) return ST_CONFLICT;
    end
    if (!any_empty) return ST_FULL;
    for (int i = 0; i < SHARED_ENTRIES; i++) begin
      if (shr_keys[i] == '0) begin
        shr_keys[i] = key;
        shr_refs[i] = CNT_W'(1);
        filled      = 1'b1;
        return ST_OK;
      end
    end
    return ST_FULL;
  endfunction

  function automatic key_result_t predict_write(input logic [SLOT_W-1:0] slot,
                                                input logic [KEY_W-1:0]  key);
    key_result_t      res;
    logic [KEY_W-1:0] prior;
    bit               filled;
    res = '{key: '0, changed: 1'b0, status: ST_OK};
    if (int'(slot) >= CONTEXT_ENTRIES) return res;
    prior = ctx_keys[slot];
    if (key != prior) begin
      if (prior[LOW_W-1:0] != '0) res.changed = release_key(prior);
      if (key[LOW_W-1:0] != '0) begin
        res.status = claim_key(key, filled);
        if (res.status != ST_OK) key = '0;
        else res.changed = res.changed | filled;
      end
      ctx_keys[slot] = key;
    end
    res.key = key;
    return res;
  endfunction

  always @(posedge clk) begin : monitor
    key_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < CONTEXT_ENTRIES; i++) ctx_keys[i] = '0;
      for (int i = 0; i < SHARED_ENTRIES; i++) begin
        shr_keys[i] = '0;
        shr_refs[i] = '0;
      end
      key_results_q.delete();
    end else begin
      if (in_valid && !in_stall)
        key_results_q.push_back(predict_write(in_slot, in_new_key));
      if (out_valid && !out_stall) begin
        if (key_results_q.size() == 0) begin
          errors = errors + 1;
          if (errors <= 10)
            $display("%0t: result with none expected: key %h changed %b status %0d",
                     $realtime, out_stored_key, out_table_changed, out_status);
        end else begin
          want = key_results_q.pop_front();
          if (out_stored_key !== want.key || out_table_changed !== want.changed ||
              out_status !== want.status) begin
            errors = errors + 1;
            if (errors <= 10)
              $display("%0t: mismatch: exp key %h changed %b status %0d, got %h %b %0d",
                       $realtime, want.key, want.changed, want.status,
                       out_stored_key, out_table_changed, out_status);
          end
        end
      end
    end
    pending = key_results_q.size();
  end

endmodule

FILE: sim/partition_key_refcount_table_test.sv
// ----------------------------------------------------------------------------
// partition_key_refcount_table_test
// Stimulus and verdict for the partition key refcount table.
// ----------------------------------------------------------------------------
// A short directed sequence walks through add, match, unchanged key, all-ones
// and zero low bits, membership conflict, removal of absent keys and the
// reuse of freed shared slots. Random phases then draw keys from a
// small per-phase pool so that matches, conflicts and a crowded shared table
// happen often, mixed with fully random keys. Both channels idle at random;
// one phase holds the result channel off for a long stretch while the input
// keeps offering, and every phase ends by draining all outstanding results.
// ----------------------------------------------------------------------------
module partition_key_refcount_table_test
  import pkrt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CTX_N       = CONTEXT_ENTRIES_DEF;
  localparam int SHR_N       = SHARED_ENTRIES_DEF;
  localparam int POOL_N      = 5;      // distinct keys per phase, one more than SHR_N
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 250;
  localparam int HOLD_CYCLES = 300;    // long receiver hold-off
  localparam int TAIL_CYCLES = 60;     // outlasts the worst item latency
  localparam int LIMIT_NS    = 5_000_000;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [SLOT_W-1:0] in_slot    = '0;
  logic [KEY_W-1:0]  in_new_key = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [KEY_W-1:0]  out_stored_key;
  logic              out_table_changed;
  logic [1:0]        out_status;

  int check_errors;
  int check_pending;

  // pacing knobs
  bit tx_quiet = 1'b0;  // sender offers back to back
  bit rx_quiet = 1'b0;  // receiver never stalls on its own
  bit hold_go  = 1'b0;  // kick off the long hold-off
  bit hold_on  = 1'b0;
  bit rx_took  = 1'b0;  // result transaction accepted at the last rising edge
  int rx_wait  = 0;

  logic [KEY_W-1:0] key_pool [POOL_N];
  logic [KEY_W-1:0] sent_key [1 << SLOT_W];

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  partition_key_refcount_table #(
    .CONTEXT_ENTRIES(CTX_N),
    .SHARED_ENTRIES (SHR_N)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_slot          (in_slot),
    .in_new_key       (in_new_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stored_key   (out_stored_key),
    .out_table_changed(out_table_changed),
    .out_status       (out_status)
  );

  partition_key_refcount_table_check #(
    .CONTEXT_ENTRIES(CTX_N),
    .SHARED_ENTRIES (SHR_N)
  ) check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_slot          (in_slot),
    .in_new_key       (in_new_key),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stored_key   (out_stored_key),
    .out_table_changed(out_table_changed),
    .out_status       (out_status),
    .errors           (check_errors),
    .pending          (check_pending)
  );

  // Receiver: note each accepted result transaction.
  always @(posedge clk) begin
    rx_took <= out_valid && !out_stall;
  end

  // Stall changes on the falling edge only; a stall length is drawn after
  // each accepted result, and the long hold-off overrides.
  always @(negedge clk) begin : rx_pace
    int left;
    left = rx_took ? (rx_quiet ? 0 : int'($urandom_range(0, 19))) : rx_wait;
    out_stall <= hold_on || (left != 0);
    rx_wait   <= (left != 0) ? left - 1 : 0;
  end

  // Long hold-off, counted here so the sender keeps running meanwhile.
  initial begin : long_hold
    wait (hold_go);
    @(negedge clk) hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on <= 1'b0;
  end

  // One input transaction: random gap, then hold until accepted.
  task automatic send_item(input logic [SLOT_W-1:0] slot, input logic [KEY_W-1:0] key);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid   <= 1'b1;
    in_slot    <= slot;
    in_new_key <= key;
    do @(posedge clk); while (in_stall);
    sent_key[slot] = key;
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    while (check_pending != 0) @(negedge clk);
  endtask

  // Mostly pool keys (exact match or flipped membership bit), plus repeats
  // of the last key sent to the slot, all-ones and zero low bits, and noise.
  function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] prev);
    int               roll;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    k    = key_pool[$urandom_range(0, POOL_N - 1)];
    if (roll < 15) k = prev;
    else if (roll < 25) k = {1'($urandom), LOW_ONES};
    else if (roll < 32) k = {1'($urandom), {LOW_W{1'b0}}};
    else if (roll < 42) k = KEY_W'($urandom);
    else if (roll < 58) k[KEY_W-1] = ~k[KEY_W-1];
    return k;
  endfunction

  initial begin : stimulus
    logic [SLOT_W-1:0] slot;
    for (int i = 0; i < (1 << SLOT_W); i++) sent_key[i] = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed
    send_item(2'd0, 16'h0001);  // new key takes a shared slot
    send_item(2'd1, 16'h0001);  // exact match, second reference
    send_item(2'd1, 16'h0001);  // unchanged key
    send_item(2'd2, 16'h8001);  // same low bits, other membership: conflict
    send_item(2'd2, 16'h7FFF);  // all-ones low bits bypass the table
    send_item(2'd3, 16'hFFFF);  // all-ones, full member
    send_item(2'd0, 16'h8000);  // zero low bits stored as is; 0001 loses a ref
    send_item(2'd1, 16'h0000);  // last ref of 0001 gone, slot freed
    send_item(2'd0, 16'h0002);  // old zero-low key is not removed
    send_item(2'd1, 16'h8003);
    send_item(2'd2, 16'h0004);  // old all-ones key absent from the table
    send_item(2'd3, 16'h7FFE);  // shared table now full
    send_item(2'd2, 16'h0005);  // frees 0004, then reuses the slot
    send_item(2'd1, 16'h0005);  // frees 8003, then matches 0005
    send_item(2'd0, 16'h0003);  // frees 0002, then reuses its slot
    send_item(2'd0, 16'h8003);  // frees 0003, then reuses its slot
    send_item(2'd3, 16'h8003);  // frees 7FFE, match
    send_item(2'd2, 16'h5555);
    send_item(2'd1, 16'hAAAA);
    send_item(2'd0, 16'hFFFE);
    send_item(2'd3, 16'h7FFF);
    send_item(2'd2, 16'h5555);
    drain();

    // random phases
    for (int phase = 0; phase < PHASES; phase++) begin
      for (int i = 0; i < POOL_N; i++)
        key_pool[i] = {1'($urandom), LOW_W'($urandom_range(1, 32766))};
      rx_quiet = (phase == 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // back-to-back stretches; phase 2 keeps offering through the hold-off
        tx_quiet = (phase == 2) ? (n < 80) : ((phase % 2 == 1) && n < 40);
        if (phase == 2 && n == 10) hold_go = 1'b1;
        slot = SLOT_W'($urandom_range(0, (1 << SLOT_W) - 1));
        send_item(slot, pick_key(sent_key[slot]));
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (check_errors == 0 && check_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
